// File: design/epm_pkg.sv
// Shared widths, codes and helper functions for the entropy pool mixer.
`timescale 1ns / 1ps

package epm_pkg;

    localparam int POOL_WORDS_DEF  = 128;
    localparam int NUM_SOURCES_DEF = 16;

    localparam int WORD_W     = 32;
    localparam int CNT_W      = 13;
    localparam int SOURCE_W   = 4;
    localparam int S_TDATA_W  = 144;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 48;
    localparam int READY_BITS = 16;

    localparam logic [1:0] KIND_TIMER = 2'd0;
    localparam logic [1:0] KIND_TRUE  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {32'd0, x} << n;
        return t[31:0] | t[63:32];
    endfunction

    function automatic logic [31:0] magnitude(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [2:0] bitlen4(input logic [3:0] v);
        logic [2:0] n;
        if (v[3]) begin
            n = 3'd4;
        end else if (v[2]) begin
            n = 3'd3;
        end else if (v[1]) begin
            n = 3'd2;
        end else if (v[0]) begin
            n = 3'd1;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

endpackage

// File: design/epm_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module epm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/entropy_pool_mixer.sv
// Entropy pool mixer: twisted-LFSR pool, per-source timing state, entropy count.
// One item at a time; the next is taken the cycle after the result is loaded.
// Each mixed word takes six reads through the single pool read port.
// Reset (sync, active low) clears control state and the valid bits.
`timescale 1ns / 1ps

module entropy_pool_mixer #(
    parameter int POOL_WORDS  = epm_pkg::POOL_WORDS_DEF,
    parameter int NUM_SOURCES = epm_pkg::NUM_SOURCES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_wr_data,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // source, value, cputimer_count, cycle_count, tick_time, pool_index, zero pad
    input  logic [epm_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // kind
    input  logic [epm_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // pool_word, ent_level, ready_res, zero pad
    output logic [epm_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);

    import epm_pkg::*;

    localparam int AW    = $clog2(POOL_WORDS);
    localparam int SW    = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int TAP_A = (POOL_WORDS == 64) ? 62 : 99;
    localparam int TAP_B = (POOL_WORDS == 64) ? 38 : 59;
    localparam int TAP_C = (POOL_WORDS == 64) ? 10 : 31;
    localparam int TAP_D = (POOL_WORDS == 64) ? 6 : 9;
    localparam int TAP_E = (POOL_WORDS == 64) ? 1 : 7;
    localparam int OFF_A = TAP_A % POOL_WORDS;
    localparam int OFF_B = TAP_B % POOL_WORDS;
    localparam int OFF_C = TAP_C % POOL_WORDS;
    localparam int OFF_D = TAP_D % POOL_WORDS;
    localparam int OFF_E = TAP_E % POOL_WORDS;
    localparam logic [13:0] CAP14 = 14'(32 * POOL_WORDS);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_MIX_START = 3'd1;
    localparam logic [2:0] ST_MIX_TAP   = 3'd2;
    localparam logic [2:0] ST_READ      = 3'd3;
    localparam logic [2:0] ST_READ_WAIT = 3'd4;
    localparam logic [2:0] ST_FIN       = 3'd5;

    localparam logic [2:0] TAP_LAST = 3'd6;

    // input fields
    logic [1:0]          w_kind;
    logic [SOURCE_W-1:0] w_source;
    logic [31:0]         w_value;
    logic [31:0]         w_cpu;
    logic [31:0]         w_cyc;
    logic [31:0]         w_tick;
    logic [6:0]          w_pidx;
    logic [7:0]          w_idx8;
    logic [31:0]         w_ev;
    logic                w_accept;

    assign w_kind   = i_s_axis_tuser;
    assign w_source = i_s_axis_tdata[3:0];
    assign w_value  = i_s_axis_tdata[35:4];
    assign w_cpu    = i_s_axis_tdata[67:36];
    assign w_cyc    = i_s_axis_tdata[99:68];
    assign w_tick   = i_s_axis_tdata[131:100];
    assign w_pidx   = i_s_axis_tdata[138:132];

    // control
    logic [2:0]             r_state;
    logic [2:0]             r_cnt;
    logic                   r_second;
    logic [1:0]             r_kind;
    logic                   r_ccp;
    logic [AW-1:0]          r_ptr;
    logic [4:0]             r_rot;
    logic [CNT_W-1:0]       r_ent;
    logic [POOL_WORDS-1:0]  r_pvalid;
    logic [NUM_SOURCES-1:0] r_svalid;
    logic [2:0]             r_dph;
    logic                   r_out_valid;

    // payload
    logic [SW-1:0]  r_src;
    logic [31:0]    r_tick;
    logic [31:0]    r_word;
    logic [AW-1:0]  r_idx;
    logic [AW-1:0]  r_p;
    logic [31:0]    r_acc;
    logic           r_rd_ok;
    logic           r_src_ok;
    logic [31:0]    r_d1;
    logic [31:0]    r_dold;
    logic [31:0]    r_d2;
    logic [31:0]    r_m1;
    logic [31:0]    r_m;
    logic [5:0]     r_n;
    logic [31:0]    r_rd_word;
    logic [M_TDATA_W-1:0] r_out_data;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_ev = w_value ^ (w_cpu << 16) ^ (r_ccp ? ~w_cyc : 32'd0);

    assign w_idx8 = ({1'b0, w_pidx} >= 8'(POOL_WORDS)) ? ({1'b0, w_pidx} - 8'(POOL_WORDS))
                                                       : {1'b0, w_pidx};

    // source wrap table
    logic [SW-1:0] w_src_map [2**SOURCE_W];
    for (genvar gi = 0; gi < 2**SOURCE_W; gi++) begin : g_src_map
        localparam int SM = gi % NUM_SOURCES;
        assign w_src_map[gi] = SW'(SM);
    end

    // pool addressing
    logic [AW-1:0] w_off;
    logic [AW:0]   w_tsum;
    logic [AW:0]   w_twrap;
    logic [AW-1:0] w_taddr;
    logic [AW-1:0] w_praddr;
    logic [AW-1:0] w_pnew;
    logic [31:0]   w_pq_raw;
    logic [31:0]   w_pq;
    logic          w_pwe;
    logic [31:0]   w_pwdata;

    always_comb begin
        case (r_cnt)
            3'd0:    w_off = AW'(OFF_A);
            3'd1:    w_off = AW'(OFF_B);
            3'd2:    w_off = AW'(OFF_C);
            3'd3:    w_off = AW'(OFF_D);
            3'd4:    w_off = AW'(OFF_E);
            default: w_off = '0;
        endcase
    end

    assign w_tsum   = {1'b0, r_p} + {1'b0, w_off};
    assign w_twrap  = (w_tsum >= (AW+1)'(POOL_WORDS)) ? (w_tsum - (AW+1)'(POOL_WORDS)) : w_tsum;
    assign w_taddr  = w_twrap[AW-1:0];
    assign w_praddr = (r_state == ST_READ) ? r_idx : w_taddr;
    assign w_pnew   = (r_ptr == '0) ? AW'(POOL_WORDS - 1) : (r_ptr - 1'b1);
    assign w_pq     = r_rd_ok ? w_pq_raw : 32'd0;
    assign w_pwe    = (r_state == ST_MIX_TAP) && (r_cnt == TAP_LAST);
    assign w_pwdata = rotl32(r_acc ^ w_pq, 5'd1);

    epm_ram #(
        .WIDTH (32),
        .DEPTH (POOL_WORDS),
        .AW    (AW)
    ) u_pool (
        .i_clk   (i_clk),
        .i_we    (w_pwe),
        .i_waddr (r_p),
        .i_wdata (w_pwdata),
        .i_raddr (w_praddr),
        .o_rdata (w_pq_raw)
    );

    // per-source timing state: {last delta, last tick}
    logic [SW-1:0] w_sraddr;
    logic [63:0]   w_sq_raw;
    logic [31:0]   w_stick;
    logic [31:0]   w_sdelta;
    logic          w_swe;
    logic [31:0]   w_m2;

    assign w_sraddr = (r_state == ST_IDLE) ? w_src_map[w_source] : r_src;
    assign w_stick  = r_src_ok ? w_sq_raw[31:0] : 32'd0;
    assign w_sdelta = r_src_ok ? w_sq_raw[63:32] : 32'd0;
    assign w_swe    = (r_dph == 3'd2);
    assign w_m2     = magnitude(r_d2);

    epm_ram #(
        .WIDTH (64),
        .DEPTH (NUM_SOURCES),
        .AW    (SW)
    ) u_src (
        .i_clk   (i_clk),
        .i_we    (w_swe),
        .i_waddr (r_src),
        .i_wdata ({r_d1, r_tick}),
        .i_raddr (w_sraddr),
        .o_rdata (w_sq_raw)
    );

    // entropy credit
    logic [5:0]       w_add;
    logic [13:0]      w_sum;
    logic [CNT_W-1:0] n_ent;
    logic             w_fin_go;

    always_comb begin
        case (r_kind)
            KIND_TIMER: w_add = 6'd2 + r_n;
            KIND_TRUE:  w_add = 6'd32;
            default:    w_add = 6'd0;
        endcase
    end

    assign w_sum    = {1'b0, r_ent} + 14'(w_add);
    assign n_ent    = (w_sum > CAP14) ? CAP14[CNT_W-1:0] : w_sum[CNT_W-1:0];
    assign w_fin_go = (r_state == ST_FIN) && (r_dph == 3'd0) &&
                      (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_second    <= 1'b0;
            r_kind      <= KIND_TIMER;
            r_ccp       <= 1'b0;
            r_ptr       <= '0;
            r_rot       <= '0;
            r_ent       <= '0;
            r_pvalid    <= '0;
            r_svalid    <= '0;
            r_dph       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_ccp <= i_cfg_wr_data;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_kind   <= w_kind;
                        r_second <= (w_kind == KIND_TIMER);
                        case (w_kind)
                            KIND_TIMER: r_state <= ST_MIX_START;
                            KIND_TRUE:  r_state <= ST_MIX_START;
                            KIND_READ:  r_state <= ST_READ;
                            default:    r_state <= ST_FIN;
                        endcase
                    end
                end
                ST_MIX_START: begin
                    r_ptr   <= w_pnew;
                    r_rot   <= r_rot + ((w_pnew != '0) ? 5'd7 : 5'd14);
                    r_cnt   <= '0;
                    r_state <= ST_MIX_TAP;
                end
                ST_MIX_TAP: begin
                    if (r_cnt == TAP_LAST) begin
                        r_pvalid[r_p] <= 1'b1;
                        r_second      <= 1'b0;
                        r_state       <= r_second ? ST_MIX_START : ST_FIN;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                ST_READ:      r_state <= ST_READ_WAIT;
                ST_READ_WAIT: r_state <= ST_FIN;
                ST_FIN: begin
                    if (w_fin_go) begin
                        r_ent   <= n_ent;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            case (r_dph)
                3'd0: begin
                    if (w_accept && (w_kind == KIND_TIMER)) begin
                        r_dph <= 3'd1;
                    end
                end
                3'd1: r_dph <= 3'd2;
                3'd2: begin
                    r_svalid[r_src] <= 1'b1;
                    r_dph           <= 3'd3;
                end
                3'd3: r_dph <= 3'd4;
                3'd4: begin
                    if (r_m[31:4] == '0) begin
                        r_dph <= 3'd0;
                    end
                end
                default: r_dph <= 3'd0;
            endcase

            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok  <= r_pvalid[w_praddr];
        r_src_ok <= r_svalid[w_sraddr];

        if (w_accept) begin
            r_src  <= w_src_map[w_source];
            r_tick <= w_tick;
            r_idx  <= w_idx8[AW-1:0];
            r_word <= (w_kind == KIND_TIMER) ? w_ev : w_value;
        end

        case (r_state)
            ST_MIX_START: begin
                r_p   <= w_pnew;
                r_acc <= rotl32(r_word, r_rot);
            end
            ST_MIX_TAP: begin
                if (r_cnt != 3'd0) begin
                    r_acc <= r_acc ^ w_pq;
                end
                if (r_cnt == TAP_LAST) begin
                    r_word <= r_tick;
                end
            end
            ST_READ_WAIT: r_rd_word <= w_pq;
            default: ;
        endcase

        case (r_dph)
            3'd1: begin
                r_d1   <= r_tick - w_stick;
                r_dold <= w_sdelta;
            end
            3'd2: begin
                r_d2 <= r_d1 - r_dold;
                r_m1 <= magnitude(r_d1);
            end
            3'd3: begin
                r_m <= ((r_m1 < w_m2) ? r_m1 : w_m2) >> 1;
                r_n <= '0;
            end
            3'd4: begin
                if (r_m[31:4] != '0) begin
                    r_m <= r_m >> 4;
                    r_n <= r_n + 6'd4;
                end else begin
                    r_n <= r_n + {3'd0, bitlen4(r_m[3:0])};
                end
            end
            default: ;
        endcase

        if (w_fin_go) begin
            r_out_data <= {2'b00, (n_ent >= CNT_W'(READY_BITS)), n_ent,
                           (r_kind == KIND_READ) ? r_rd_word : 32'd0};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[44:32] <= CAP14[CNT_W-1:0]))
        else $error("entropy count above pool capacity");

    a_ready_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[45] == (o_m_axis_tdata[44:32] >= CNT_W'(READY_BITS))))
        else $error("ready flag disagrees with count");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_ptr} < (AW+1)'(POOL_WORDS))
        else $error("write pointer outside pool");

    a_timer_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_kind == KIND_TIMER)) |=>
            ((r_dph == 3'd1) && (r_state == ST_MIX_START)))
        else $error("timer event did not start delta and mix");
`endif

endmodule
